// ----- rtl/core/dmsc_pkg.sv -----
// Shared constants, types and helpers for the direct-mapped score cache.
`timescale 1ns / 1ps

package dmsc_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 4096;

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;
  localparam int OCC_W   = 13;
  localparam int CNT_W   = 32;

  // One table entry is {valid, key, white-relative score}.
  localparam int ENTRY_W = 1 + KEY_W + SCORE_W;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic clear;
    logic probe;
    logic hit;
    logic fill;
    logic collide;
  } stats_evt_t;

  typedef struct packed {
    logic [OCC_W-1:0] occupied;
    logic [CNT_W-1:0] probes;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] collisions;
  } stats_t;

  // Converts between side-relative and white-relative scores.
  function automatic logic signed [SCORE_W-1:0] side_flip(
    input logic signed [SCORE_W-1:0] v,
    input logic                      black
  );
    return black ? (SCORE_W'(0) - v) : v;
  endfunction

endpackage

// ----- rtl/core/dmsc_if.sv -----
// Channel interfaces for requests into and results out of the score cache.
`timescale 1ns / 1ps

interface dmsc_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                op;
  logic [dmsc_pkg::KEY_W-1:0]                position_key;
  logic                                      black_to_move;
  logic signed [dmsc_pkg::SCORE_W-1:0]       score_in;

  modport source (output valid, op, position_key, black_to_move, score_in, input ready);
  modport sink (input valid, op, position_key, black_to_move, score_in, output ready);
endinterface

interface dmsc_out_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      hit;
  logic signed [dmsc_pkg::SCORE_W-1:0]       score_out;
  logic [dmsc_pkg::OCC_W-1:0]                occupied_count;
  logic [dmsc_pkg::CNT_W-1:0]                probe_count;
  logic [dmsc_pkg::CNT_W-1:0]                hit_count;
  logic [dmsc_pkg::CNT_W-1:0]                collision_count;

  modport source (output valid, hit, score_out, occupied_count, probe_count, hit_count,
                  collision_count, input ready);
  modport sink (input valid, hit, score_out, occupied_count, probe_count, hit_count,
                collision_count, output ready);
endinterface

// ----- rtl/core/dmsc_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module dmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/dmsc_stats.sv -----
// Saturating occupancy, probe, hit and collision counters.
`timescale 1ns / 1ps

module dmsc_stats (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 commit,
  input  dmsc_pkg::stats_evt_t evt,
  output dmsc_pkg::stats_t     stats_next
);

  dmsc_pkg::stats_t stats;

  function automatic logic [dmsc_pkg::CNT_W-1:0] sat_inc(
    input logic [dmsc_pkg::CNT_W-1:0] v,
    input logic                       en
  );
    return (en && v != dmsc_pkg::CNT_MAX) ? v + 1'b1 : v;
  endfunction

  always_comb begin
    stats_next = stats;
    if (evt.clear) begin
      stats_next = '0;
    end else begin
      if (evt.fill && stats.occupied != dmsc_pkg::OCC_MAX) begin
        stats_next.occupied = stats.occupied + 1'b1;
      end
      stats_next.probes     = sat_inc(stats.probes, evt.probe);
      stats_next.hits       = sat_inc(stats.hits, evt.hit);
      stats_next.collisions = sat_inc(stats.collisions, evt.collide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (commit) begin
      stats <= stats_next;
    end
  end

endmodule

// ----- rtl/core/direct_mapped_score_cache.sv -----
// Top level of the direct-mapped, always-replace position score cache.
// For a probe or store, the accept cycle issues the read of the entry memory; the lookup
// state then compares the key, writes the entry on a store and loads the result register,
// waiting there while the previous result has not been taken. A new item is accepted only
// after the previous one has committed. A clear walks the memory one entry per cycle, then
// commits its result through the lookup state. After reset the same pass runs before the
// first transaction is accepted. Stored scores are kept white-relative; the valid bit, not a
// sentinel score, marks an occupied entry.
`timescale 1ns / 1ps

module direct_mapped_score_cache #(
  parameter int TABLE_DEPTH = dmsc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  dmsc_in_if.sink     item,
  dmsc_out_if.source  result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_SWEEP  = 2'd3;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [IDX_W-1:0]                    sweep_idx;
  logic                                sweep_last;

  logic [1:0]                          cap_op;
  logic [dmsc_pkg::KEY_W-1:0]          cap_key;
  logic                                cap_black;
  logic signed [dmsc_pkg::SCORE_W-1:0] cap_score;

  logic                                accept;
  logic                                out_free;
  logic                                commit;

  logic                                ram_we;
  logic [IDX_W-1:0]                    ram_waddr;
  logic [dmsc_pkg::ENTRY_W-1:0]        ram_wdata;
  logic [dmsc_pkg::ENTRY_W-1:0]        ram_rdata;

  logic                                ent_valid;
  logic [dmsc_pkg::KEY_W-1:0]          ent_key;
  logic signed [dmsc_pkg::SCORE_W-1:0] ent_score;
  logic                                key_match;
  logic                                probe_hit;

  dmsc_pkg::stats_evt_t                evt;
  dmsc_pkg::stats_t                    stats_next;

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);
  assign out_free   = !result.valid || result.ready;
  assign commit     = (state == ST_LOOKUP) && out_free;
  assign sweep_last = (sweep_idx == IDX_W'(TABLE_DEPTH - 1));

  assign ent_valid = ram_rdata[dmsc_pkg::ENTRY_W-1];
  assign ent_key   = ram_rdata[dmsc_pkg::SCORE_W +: dmsc_pkg::KEY_W];
  assign ent_score = ram_rdata[dmsc_pkg::SCORE_W-1:0];
  assign key_match = ent_valid && (ent_key == cap_key);
  assign probe_hit = (cap_op == dmsc_pkg::OP_PROBE) && key_match;

  // Both the reset pass and a clear write empty entries through the sweep index.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cap_key[IDX_W-1:0];
    ram_wdata = {1'b1, cap_key, dmsc_pkg::side_flip(cap_score, cap_black)};
    if (state == ST_INIT || state == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_idx;
      ram_wdata = '0;
    end else if (commit && cap_op == dmsc_pkg::OP_STORE) begin
      ram_we = 1'b1;
    end
  end

  dmsc_ram #(
    .WIDTH (dmsc_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (item.position_key[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    evt         = '0;
    evt.clear   = cap_op == dmsc_pkg::OP_CLEAR;
    evt.probe   = cap_op == dmsc_pkg::OP_PROBE;
    evt.hit     = probe_hit;
    evt.fill    = (cap_op == dmsc_pkg::OP_STORE) && !ent_valid;
    evt.collide = (cap_op == dmsc_pkg::OP_STORE) && ent_valid && !key_match;
  end

  dmsc_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .commit     (commit),
    .evt        (evt),
    .stats_next (stats_next)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.op == dmsc_pkg::OP_CLEAR) ? ST_SWEEP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_next = ST_LOOKUP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
      end else begin
        sweep_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_op    <= item.op;
      cap_key   <= item.position_key;
      cap_black <= item.black_to_move;
      cap_score <= item.score_in;
    end
  end

  // The result register lets the next transaction be accepted while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.hit             <= probe_hit;
      result.score_out       <= probe_hit ? dmsc_pkg::side_flip(ent_score, cap_black) : '0;
      result.occupied_count  <= stats_next.occupied;
      result.probe_count     <= stats_next.probes;
      result.hit_count       <= stats_next.hits;
      result.collision_count <= stats_next.collisions;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the direct-mapped score cache: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = dmsc_pkg::TABLE_DEPTH_DEFAULT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int RANDOM_PER_PHASE = 517;
  localparam int POOL_SIZE = 64;
  localparam int POOL_SLOTS = 24;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic                                hit;
    logic signed [dmsc_pkg::SCORE_W-1:0] score;
    logic [dmsc_pkg::OCC_W-1:0]          occupied;
    logic [dmsc_pkg::CNT_W-1:0]          probes;
    logic [dmsc_pkg::CNT_W-1:0]          hits;
    logic [dmsc_pkg::CNT_W-1:0]          collisions;
  } cache_result_t;

  typedef struct {
    logic [1:0]                          op;
    logic [dmsc_pkg::KEY_W-1:0]          key;
    logic                                black;
    logic signed [dmsc_pkg::SCORE_W-1:0] score;
    bit                                  typed;
    cache_result_t                       want;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dmsc_in_if  item_ch ();
  dmsc_out_if result_ch ();

  direct_mapped_score_cache #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the cache contents and statistics, advanced on every accepted transaction.
  bit                           slot_valid [DEPTH];
  logic [dmsc_pkg::KEY_W-1:0]   slot_key   [DEPTH];
  logic [dmsc_pkg::SCORE_W-1:0] slot_score [DEPTH];
  logic [dmsc_pkg::OCC_W-1:0]   occ_now     = '0;
  logic [dmsc_pkg::CNT_W-1:0]   probe_now   = '0;
  logic [dmsc_pkg::CNT_W-1:0]   hit_now     = '0;
  logic [dmsc_pkg::CNT_W-1:0]   collide_now = '0;

  cache_result_t pending_results [$];

  int  errors = 0;
  int  results_checked = 0;
  int  hits_seen = 0;
  int  peak_occupancy = 0;
  int  op_seen [4];
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  int  hold_off_reqs = 0;

  logic signed [dmsc_pkg::SCORE_W-1:0] score_edges [6] = '{
    32'sd2147483647, -32'sd2147483647, 32'sh8000_0000, 32'sd0, 32'sd1, -32'sd1
  };

  function automatic logic [dmsc_pkg::CNT_W-1:0] sat_bump(logic [dmsc_pkg::CNT_W-1:0] v);
    return (v == dmsc_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic cache_result_t predict_cache_result(logic [1:0] op,
                                                         logic [dmsc_pkg::KEY_W-1:0] key,
                                                         logic black,
                                                         logic signed [dmsc_pkg::SCORE_W-1:0] score);
    logic [IDX_W-1:0] idx;
    cache_result_t r;
    idx = key[IDX_W-1:0];
    r = '0;
    case (op)
      dmsc_pkg::OP_PROBE: begin
        probe_now = sat_bump(probe_now);
        if (slot_valid[idx] && slot_key[idx] == key) begin
          r.hit = 1'b1;
          r.score = black ? ~slot_score[idx] + 1'b1 : slot_score[idx];
          hit_now = sat_bump(hit_now);
        end
      end
      dmsc_pkg::OP_STORE: begin
        if (!slot_valid[idx]) begin
          if (occ_now != dmsc_pkg::OCC_MAX) occ_now = occ_now + 1'b1;
        end else if (slot_key[idx] != key) begin
          collide_now = sat_bump(collide_now);
        end
        slot_valid[idx] = 1'b1;
        slot_key[idx] = key;
        // The table holds scores from white's point of view.
        slot_score[idx] = black ? ~score + 1'b1 : score;
      end
      dmsc_pkg::OP_CLEAR: begin
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        occ_now = '0;
        probe_now = '0;
        hit_now = '0;
        collide_now = '0;
      end
      default: ;
    endcase
    r.occupied = occ_now;
    r.probes = probe_now;
    r.hits = hit_now;
    r.collisions = collide_now;
    return r;
  endfunction

  function automatic cache_result_t outcome(int h, logic signed [dmsc_pkg::SCORE_W-1:0] s,
                                            int occ, int p, int hh, int c);
    cache_result_t r;
    r.hit = 1'(h);
    r.score = s;
    r.occupied = dmsc_pkg::OCC_W'(occ);
    r.probes = dmsc_pkg::CNT_W'(p);
    r.hits = dmsc_pkg::CNT_W'(hh);
    r.collisions = dmsc_pkg::CNT_W'(c);
    return r;
  endfunction

  function automatic req_row_t mk_row(logic [1:0] op, logic [dmsc_pkg::KEY_W-1:0] key,
                                      logic black, logic signed [dmsc_pkg::SCORE_W-1:0] score,
                                      int typed, cache_result_t want);
    req_row_t rq;
    rq.op = op;
    rq.key = key;
    rq.black = black;
    rq.score = score;
    rq.typed = (typed != 0);
    rq.want = want;
    return rq;
  endfunction

  task automatic send_request(req_row_t rq);
    cache_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= rq.op;
    item_ch.position_key <= rq.key;
    item_ch.black_to_move <= rq.black;
    item_ch.score_in <= rq.score;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    predicted = predict_cache_result(rq.op, rq.key, rq.black, rq.score);
    pending_results.push_back(rq.typed ? rq.want : predicted);
    op_seen[rq.op]++;
    if (predicted.occupied > peak_occupancy) peak_occupancy = predicted.occupied;
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t seen;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      seen = {result_ch.hit, result_ch.score_out, result_ch.occupied_count,
              result_ch.probe_count, result_ch.hit_count, result_ch.collision_count};
      results_checked++;
      if (seen.hit === 1'b1) hits_seen++;
      if (pending_results.size() == 0) begin
        $error("Result transaction with no request outstanding: hit %0d, score %0d",
               seen.hit, seen.score);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", want.hit, seen.hit);
        compare_field("score_out", want.score, seen.score);
        compare_field("occupied_count", want.occupied, seen.occupied);
        compare_field("probe_count", want.probes, seen.probes);
        compare_field("hit_count", want.hits, seen.hits);
        compare_field("collision_count", want.collisions, seen.collisions);
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != hold_served) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_served = hold_off_reqs;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
             pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    req_row_t                    directed [$];
    req_row_t                    rq;
    logic [dmsc_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [IDX_W-1:0]            pool_slot [POOL_SLOTS];
    logic [dmsc_pkg::KEY_W-1:0]  base_key;
    int                          pick;

    item_ch.valid = 1'b0;
    item_ch.op = dmsc_pkg::OP_PROBE;
    item_ch.position_key = '0;
    item_ch.black_to_move = 1'b0;
    item_ch.score_in = '0;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Entry 0 sees key 0, key 'h1000 and a key with all high bits set, so collisions,
    // same-key rewrites and key mismatches on a valid entry all show up early.
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h0, 1'b0, 32'sd0, 1,
                              outcome(0, 0, 0, 1, 0, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'h0, 1'b0, 32'sd2147483647, 1,
                              outcome(0, 0, 1, 1, 0, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h0, 1'b0, 32'sd0, 1,
                              outcome(1, 32'sd2147483647, 1, 2, 1, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h0, 1'b1, 32'sd0, 1,
                              outcome(1, -32'sd2147483647, 1, 3, 2, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, '1, 1'b1, -32'sd2147483647, 1,
                              outcome(0, 0, 2, 3, 2, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, '1, 1'b0, 32'sd0, 1,
                              outcome(1, 32'sd2147483647, 2, 4, 3, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'h1000, 1'b0, 32'sd5, 1,
                              outcome(0, 0, 2, 4, 3, 1)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h0, 1'b0, 32'sd0, 1,
                              outcome(0, 0, 2, 5, 3, 1)));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'h1000, 1'b1, 32'sd7, 1,
                              outcome(0, 0, 2, 5, 3, 1)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h1000, 1'b0, 32'sd0, 1,
                              outcome(1, -32'sd7, 2, 6, 4, 1)));
    // The most negative score survives negation unchanged.
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'h5, 1'b1, 32'sh8000_0000, 1,
                              outcome(0, 0, 3, 6, 4, 1)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h5, 1'b1, 32'sd0, 1,
                              outcome(1, 32'sh8000_0000, 3, 7, 5, 1)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h5, 1'b0, 32'sd0, 1,
                              outcome(1, 32'sh8000_0000, 3, 8, 6, 1)));
    directed.push_back(mk_row(OP_IDLE, 64'hDEAD_BEEF_0000_0FFF, 1'b1, 32'sd123, 1,
                              outcome(0, 0, 3, 8, 6, 1)));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_F000, 1'b0, 32'sd0, 1,
                              outcome(0, 0, 3, 8, 6, 2)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_F000, 1'b1, 32'sd0, 1,
                              outcome(1, 0, 3, 9, 7, 2)));
    directed.push_back(mk_row(dmsc_pkg::OP_CLEAR, 64'h0, 1'b0, 32'sd0, 1,
                              outcome(0, 0, 0, 0, 0, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h1000, 1'b0, 32'sd0, 1,
                              outcome(0, 0, 0, 1, 0, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h5, 1'b1, 32'sd99, 1,
                              outcome(0, 0, 0, 2, 0, 0)));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'h8000_0000_0000_0ABC, 1'b1, 32'sd1000,
                              0, '0));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, 64'h0000_0000_0000_1ABC, 1'b0, -32'sd1,
                              0, '0));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h0000_0000_0000_1ABC, 1'b1, 32'sd0,
                              0, '0));
    directed.push_back(mk_row(dmsc_pkg::OP_PROBE, 64'h8000_0000_0000_0ABC, 1'b0, 32'sd0,
                              0, '0));
    directed.push_back(mk_row(dmsc_pkg::OP_STORE, '1, 1'b0, -32'sd2147483647, 0, '0));
    directed.push_back(mk_row(dmsc_pkg::OP_CLEAR, '1, 1'b1, -32'sd1, 1,
                              outcome(0, 0, 0, 0, 0, 0)));

    snd_idle_pct = 22;
    rcv_idle_pct = 59;
    foreach (directed[i]) send_request(directed[i]);

    // A small pool of keys crowded onto a few entries gives frequent hits and collisions.
    foreach (pool_slot[i]) begin
      pool_slot[i] = (i == 0) ? '0 : (i == 1) ? '1 : IDX_W'($urandom_range(0, DEPTH - 1));
    end
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom(), $urandom()};
      key_pool[i][IDX_W-1:0] = pool_slot[$urandom_range(0, POOL_SLOTS - 1)];
    end

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 59 : 0;
      rcv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 22 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 0 && n == 150) hold_off_reqs++;
        if (ph == 1 && n == 200) drain_results();
        pick = $urandom_range(0, 999);
        rq.op = (pick < 4) ? dmsc_pkg::OP_CLEAR : (pick < 30) ? OP_IDLE :
                (pick < 520) ? dmsc_pkg::OP_PROBE : dmsc_pkg::OP_STORE;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 85) begin
          // Same entry as a pooled key, but a different tag.
          base_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          rq.key = {$urandom(), $urandom()};
          rq.key[IDX_W-1:0] = base_key[IDX_W-1:0];
        end else begin
          rq.key = {$urandom(), $urandom()};
        end
        rq.black = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) rq.score = score_edges[$urandom_range(0, 5)];
        else rq.score = $urandom();
        rq.typed = 1'b0;
        rq.want = '0;
        send_request(rq);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d probes, %0d stores, %0d clears and %0d idle codes.",
             op_seen[dmsc_pkg::OP_PROBE], op_seen[dmsc_pkg::OP_STORE],
             op_seen[dmsc_pkg::OP_CLEAR], op_seen[OP_IDLE]);
    $display("Checked %0d results with %0d probe hits; peak occupancy %0d entries.",
             results_checked, hits_seen, peak_occupancy);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dmsc_pkg.sv
rtl/core/dmsc_if.sv
rtl/core/dmsc_ram.sv
rtl/core/dmsc_stats.sv
rtl/core/direct_mapped_score_cache.sv
tb/tb.sv
